### rtl/core/ime_pkg.sv
// Shared types and constants of the inverted Mandelbrot escape-time block.
`timescale 1ns / 1ps
`default_nettype none
package ime_pkg;
    localparam int COORD_FRAC_BITS_DEF = 26;
    localparam int Z_FRAC              = 34;
    localparam int COORD_W             = 32;
    localparam int ITER_W              = 8;
    localparam logic [ITER_W-1:0] LIMIT_RESET = 8'd200;

    // One point after the front end: magnitudes, signs and m^2 + n^2.
    typedef struct packed {
        logic [COORD_W-1:0]   am;
        logic [COORD_W-1:0]   an;
        logic                 neg_m;
        logic                 neg_n;
        logic                 zero;
        logic [2*COORD_W-1:0] d;
    } t_job;
endpackage
`default_nettype wire

### rtl/core/ime_if.sv
// Valid/ready channel interfaces for points and for escape results.
`timescale 1ns / 1ps
`default_nettype none
interface ime_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] real_coord;
    logic [31:0] imag_coord;
    modport source (output valid, output real_coord, output imag_coord, input ready);
    modport sink   (input valid, input real_coord, input imag_coord, output ready);
endinterface

interface ime_out_if;
    logic       valid;
    logic       ready;
    logic       escaped;
    logic [7:0] iterations;
    modport source (output valid, output escaped, output iterations, input ready);
    modport sink   (input valid, input escaped, input iterations, output ready);
endinterface
`default_nettype wire

### rtl/core/ime_front.sv
// Front end: takes a point, forms the magnitudes and the divisor m^2 + n^2.
`timescale 1ns / 1ps
`default_nettype none
module ime_front import ime_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ime_in_if.sink    i_pt,
    output t_job      o_job,
    output logic      o_push,
    input  wire logic i_full
);
    typedef enum logic [1:0] {F_IDLE, F_SQ_M, F_SQ_N, F_PUSH} t_fstate;

    t_fstate r_state;
    t_job    r_job;
    logic [COORD_W-1:0]   sq_op;
    logic [2*COORD_W-1:0] sq;

    // One 32x32 multiplier squares the two magnitudes in turn.
    assign sq_op = (r_state == F_SQ_M) ? r_job.am : r_job.an;
    assign sq    = (2*COORD_W)'(sq_op) * (2*COORD_W)'(sq_op);

    assign i_pt.ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_job      = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_pt.valid) begin
                        r_job.neg_m <= i_pt.real_coord[COORD_W-1];
                        r_job.neg_n <= i_pt.imag_coord[COORD_W-1];
                        r_job.am    <= i_pt.real_coord[COORD_W-1] ?
                                       (~i_pt.real_coord + 1'b1) : i_pt.real_coord;
                        r_job.an    <= i_pt.imag_coord[COORD_W-1] ?
                                       (~i_pt.imag_coord + 1'b1) : i_pt.imag_coord;
                        r_state     <= F_SQ_M;
                    end
                end
                F_SQ_M: begin
                    r_job.d <= sq;
                    r_state <= F_SQ_N;
                end
                F_SQ_N: begin
                    r_job.d    <= r_job.d + sq;
                    r_job.zero <= (r_job.am == '0) && (r_job.an == '0);
                    r_state    <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/ime_queue.sv
// Two-entry queue of prepared points between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ime_queue import ime_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);
    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

### rtl/core/ime_back.sv
// Back end: reciprocal by restoring division, then the z = z*z + c iteration.
`timescale 1ns / 1ps
`default_nettype none
module ime_back import ime_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [ITER_W-1:0] i_limit,
    input  wire logic              i_q_valid,
    input  wire t_job              i_q_job,
    output logic                   o_pop,
    ime_out_if.source              o_res
);
    localparam int DIV_STEPS = COORD_W + COORD_FRAC_BITS + Z_FRAC;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int QW        = 38;              // holds the cap 2^37
    localparam int ZW        = 40;              // z and c, signed Q6.34
    localparam int HW        = ZW / 2;          // multiplier operand half
    localparam int PW        = ZW + HW;         // partial product width
    localparam int SW        = 48;              // truncated products
    localparam logic [QW:0]   CAP39   = (QW+1)'(1) << 37;
    localparam logic [QW-1:0] CAP     = QW'(1) << 37;
    localparam logic signed [ZW:0] CAP_S   = (ZW+1)'(1) << 37;
    localparam logic signed [ZW:0] QUARTER = (ZW+1)'(1) << 32;
    localparam logic signed [SW-1:0] ESC   = SW'(1) << 36;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL_LO, B_MUL_HI, B_SUM, B_TEST,
                              B_OUT} t_bstate;

    t_bstate r_state;
    t_job    r_job;
    logic [COORD_W-1:0]   r_dvd;
    logic [2*COORD_W-1:0] r_rem;
    logic [QW:0]          r_q;
    logic                 r_sat;
    logic [STEP_W-1:0]    r_step;
    logic                 r_second;
    logic [QW-1:0]        r_qm;
    logic signed [ZW-1:0] r_cre, r_cim, r_zr, r_zi;
    logic [ITER_W-1:0]    r_t;
    logic [PW-1:0]        r_lo_xx, r_lo_yy, r_lo_xy, r_hi_xx, r_hi_yy, r_hi_xy;
    logic signed [SW-1:0] r_xx, r_yy, r_xy;
    logic                 r_res_esc;
    logic [ITER_W-1:0]    r_res_it;
    logic                 r_out_valid, r_out_esc;
    logic [ITER_W-1:0]    r_out_it;

    // Divider step.
    logic [2*COORD_W-1:0] div_trial, div_rem_n;
    logic                 div_ge, div_sat_n;
    logic [QW:0]          div_q_n;
    logic [QW-1:0]        div_quo;
    always_comb begin
        div_trial = {r_rem[2*COORD_W-2:0], r_dvd[COORD_W-1]};
        div_ge    = (div_trial >= r_job.d);
        div_rem_n = div_ge ? (div_trial - r_job.d) : div_trial;
        div_q_n   = {r_q[QW-1:0], div_ge};
        div_sat_n = r_sat || (div_q_n > CAP39);
        div_quo   = div_sat_n ? CAP : div_q_n[QW-1:0];
    end

    // c from the two quotients, real part offset by 0.25 and clamped.
    logic signed [ZW:0] cre_w, cre_c, cim_w;
    always_comb begin
        cre_w = r_job.neg_m ? -$signed({3'b0, r_qm}) : $signed({3'b0, r_qm});
        cre_w = cre_w + QUARTER;
        if (cre_w > CAP_S)       cre_c = CAP_S;
        else if (cre_w < -CAP_S) cre_c = -CAP_S;
        else                     cre_c = cre_w;
        cim_w = r_job.neg_n ? $signed({3'b0, div_quo}) : -$signed({3'b0, div_quo});
    end

    // Three 40x20 multipliers; each product takes a low and a high half.
    logic [ZW-1:0] mr, mi;
    logic [HW-1:0] hr, hi;
    logic [PW-1:0] p_xx, p_yy, p_xy;
    assign mr   = r_zr[ZW-1] ? ZW'(-r_zr) : ZW'(r_zr);
    assign mi   = r_zi[ZW-1] ? ZW'(-r_zi) : ZW'(r_zi);
    assign hr   = (r_state == B_MUL_HI) ? mr[ZW-1:HW] : mr[HW-1:0];
    assign hi   = (r_state == B_MUL_HI) ? mi[ZW-1:HW] : mi[HW-1:0];
    assign p_xx = PW'(mr) * PW'(hr);
    assign p_yy = PW'(mi) * PW'(hi);
    assign p_xy = PW'(mr) * PW'(hi);

    logic [2*ZW-1:0] f_xx, f_yy, f_xy;
    logic signed [SW-1:0] s_xy;
    always_comb begin
        f_xx = (2*ZW)'(r_lo_xx) + {r_hi_xx, HW'(0)};
        f_yy = (2*ZW)'(r_lo_yy) + {r_hi_yy, HW'(0)};
        f_xy = (2*ZW)'(r_lo_xy) + {r_hi_xy, HW'(0)};
        s_xy = $signed(SW'(f_xy[2*ZW-1:Z_FRAC]));
        if (r_zr[ZW-1] != r_zi[ZW-1]) s_xy = -s_xy;
    end

    logic                 esc_now;
    logic signed [SW-1:0] zr_w, zi_w;
    assign esc_now = (r_xx + r_yy) > ESC;
    assign zr_w    = r_xx - r_yy + SW'(r_cre);
    assign zi_w    = (r_xy <<< 1) + SW'(r_cim);

    assign o_pop       = (r_state == B_IDLE) && i_q_valid;
    assign o_res.valid      = r_out_valid;
    assign o_res.escaped    = r_out_esc;
    assign o_res.iterations = r_out_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In B_OUT the output register is handled by that state alone.
            if (o_res.ready && (r_state != B_OUT)) r_out_valid <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_job    <= i_q_job;
                        r_dvd    <= i_q_job.am;
                        r_rem    <= '0;
                        r_q      <= '0;
                        r_sat    <= 1'b0;
                        r_step   <= '0;
                        r_second <= 1'b0;
                        if (i_q_job.zero) begin
                            r_res_esc <= 1'b0;
                            r_res_it  <= i_limit;
                            r_state   <= B_OUT;
                        end else begin
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    r_dvd  <= r_dvd << 1;
                    r_rem  <= div_rem_n;
                    r_q    <= div_q_n;
                    r_sat  <= div_sat_n;
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        if (!r_second) begin
                            r_qm     <= div_quo;
                            r_dvd    <= r_job.an;
                            r_rem    <= '0;
                            r_q      <= '0;
                            r_sat    <= 1'b0;
                            r_step   <= '0;
                            r_second <= 1'b1;
                        end else begin
                            r_cre <= ZW'(cre_c);
                            r_cim <= ZW'(cim_w);
                            r_zr  <= '0;
                            r_zi  <= '0;
                            r_t   <= '0;
                            if (i_limit == '0) begin
                                r_res_esc <= 1'b0;
                                r_res_it  <= i_limit;
                                r_state   <= B_OUT;
                            end else begin
                                r_state <= B_MUL_LO;
                            end
                        end
                    end
                end
                B_MUL_LO: begin
                    r_lo_xx <= p_xx;
                    r_lo_yy <= p_yy;
                    r_lo_xy <= p_xy;
                    r_state <= B_MUL_HI;
                end
                B_MUL_HI: begin
                    r_hi_xx <= p_xx;
                    r_hi_yy <= p_yy;
                    r_hi_xy <= p_xy;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_xx    <= $signed(SW'(f_xx[2*ZW-1:Z_FRAC]));
                    r_yy    <= $signed(SW'(f_yy[2*ZW-1:Z_FRAC]));
                    r_xy    <= s_xy;
                    r_state <= B_TEST;
                end
                B_TEST: begin
                    if (esc_now) begin
                        r_res_esc <= 1'b1;
                        r_res_it  <= r_t;
                        r_state   <= B_OUT;
                    end else begin
                        r_zr <= ZW'(zr_w);
                        r_zi <= ZW'(zi_w);
                        r_t  <= r_t + 1'b1;
                        if (r_t + 1'b1 == i_limit) begin
                            r_res_esc <= 1'b0;
                            r_res_it  <= i_limit;
                            r_state   <= B_OUT;
                        end else begin
                            r_state <= B_MUL_LO;
                        end
                    end
                end
                B_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_esc   <= r_res_esc;
                        r_out_it    <= r_res_it;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_esc_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_esc) |-> (r_out_it < i_limit))
        else $error("escape index not below the limit");
    a_noesc_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_esc) |-> (r_out_it == i_limit))
        else $error("non-escape result not at the limit");
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_step < STEP_W'(DIV_STEPS)))
        else $error("divider ran past its step count");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TEST) |-> (r_t < i_limit))
        else $error("iteration index reached the limit");
endmodule
`default_nettype wire

### rtl/core/inverted_mandelbrot_escape_top.sv
// Top level of the inverted Mandelbrot escape-time block.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on i_pt carries one point m+ni in signed fixed point with
// COORD_FRAC_BITS fraction bits. The block forms c = 1/(m+ni) + 0.25 in Q6.34,
// clamping each part of c to plus or minus 8, iterates z = z*z + c from z = 0
// and returns one transaction on o_res: whether |z|^2 exceeded 4 and the
// iteration index at which it did, or the iteration limit if it never did.
// A zero point, and a limit of zero, give escaped = 0 with the count equal to
// the limit. The front end takes a point, squares its two magnitudes in turn
// and hands it to a two-entry queue, so a new point can be taken while the
// back end works. The back end takes a point from the queue, runs the two
// restoring divisions of the reciprocal, then runs each iteration through the
// states B_MUL_LO, B_MUL_HI, B_SUM and B_TEST with its three shared 40x20
// multipliers, and finally loads the output register. The iteration limit
// (reset value 200) is written through i_cfg_we and i_cfg_wdata and must
// only change while no point is in flight.
module inverted_mandelbrot_escape_top import ime_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ITER_W-1:0] i_cfg_wdata,
    ime_in_if.sink                 i_pt,
    ime_out_if.source              o_res
);
    logic [ITER_W-1:0] r_limit;
    t_job f_job, q_job;
    logic f_push, q_full, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    ime_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .o_job   (f_job),
        .o_push  (f_push),
        .i_full  (q_full)
    );

    ime_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ime_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (r_limit),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench of the inverted Mandelbrot escape-time block.
`timescale 1ns / 1ps
module tb_top;
    import ime_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ITER_W-1:0] i_cfg_wdata = '0;

    ime_in_if  pt_if ();
    ime_out_if res_if ();

    inverted_mandelbrot_escape_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (pt_if),
        .o_res       (res_if)
    );

    // The clock toggles every half period of 5 ns.
    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic             escaped;
        logic [ITER_W-1:0] iterations;
    } escape_t;

    localparam int          RECIP_SHIFT = COORD_FRAC_BITS_DEF + Z_FRAC;
    localparam logic [127:0] C_CAP      = 128'd1 << 37;
    localparam longint      QUARTER     = 64'sd1 <<< 32;
    localparam longint      ESCAPE_R2   = 64'sd1 <<< 36;

    escape_t     pending_escapes[$];
    logic [7:0]  shadow_limit = LIMIT_RESET;
    int          error_count = 0;
    int          burst_left = 0;
    logic        hold_request = 1'b0;

    // Fixed-point product of two Q6.34 values, truncated toward zero in magnitude.
    function automatic longint fix_mul(longint a, longint b);
        logic         neg;
        logic [127:0] ua, ub, prod;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 128'(-a) : 128'(a);
        ub   = (b < 0) ? 128'(-b) : 128'(b);
        prod = (ua * ub) >> Z_FRAC;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Magnitude of one part of 1/p, clamped to 8.0.
    function automatic longint recip_part(logic [63:0] mag, logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, mag} << RECIP_SHIFT) / {64'd0, d};
        if (q > C_CAP) q = C_CAP;
        return longint'(q[63:0]);
    endfunction

    // Expected escape result of one point under the given iteration limit.
    function automatic escape_t predict_escape(logic [31:0] m, logic [31:0] n,
                                               logic [7:0] limit);
        escape_t     r;
        logic [63:0] am, an, d;
        longint      cre, cim, zr, zi, xx, yy, xy;
        am = m[31] ? (64'h1_0000_0000 - {32'd0, m}) : {32'd0, m};
        an = n[31] ? (64'h1_0000_0000 - {32'd0, n}) : {32'd0, n};
        d  = am * am + an * an;
        r.escaped    = 1'b0;
        r.iterations = limit;
        if (d == 0) return r;
        cre = recip_part(am, d);
        cim = recip_part(an, d);
        if (m[31]) cre = -cre;
        if (!n[31]) cim = -cim;
        cre = cre + QUARTER;
        if (cre > longint'(C_CAP)) cre = longint'(C_CAP);
        if (cre < -longint'(C_CAP)) cre = -longint'(C_CAP);
        zr = 0;
        zi = 0;
        for (int t = 0; t < limit; t++) begin
            xx = fix_mul(zr, zr);
            yy = fix_mul(zi, zi);
            if (xx + yy > ESCAPE_R2) begin
                r.escaped    = 1'b1;
                r.iterations = t[7:0];
                return r;
            end
            xy = fix_mul(zr, zi);
            zr = xx - yy + cre;
            zi = 2 * xy + cim;
        end
        return r;
    endfunction

    // Offers one point and waits for its transaction. The sender works in
    // bursts; between bursts it drops valid for a random gap.
    task automatic send_point(logic [31:0] m, logic [31:0] n);
        pt_if.valid      <= 1'b1;
        pt_if.real_coord <= m;
        pt_if.imag_coord <= n;
        do @(posedge i_clk); while (!pt_if.ready);
        pending_escapes.push_back(predict_escape(m, n, shadow_limit));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(4, 20);
            pt_if.valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 250) : $urandom_range(1, 6))
                @(posedge i_clk);
        end
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic drain_results();
        pt_if.valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Writes the iteration limit; only called while nothing is in flight.
    task automatic write_limit(logic [7:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_limit = value;
    endtask

    // Random coordinate drawn from several magnitude bands so that both
    // escaping and bounded regions of the inverted plane are reached.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 28)) - 2 ** 27);
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return 32'($signed($urandom_range(0, 2 ** 29)) - 2 ** 28);
            default: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
        endcase
    endfunction

    task automatic send_random(int count);
        for (int k = 0; k < count; k++) send_point(rand_coord(), rand_coord());
    endtask

    // Extremes of the coordinates, the zero point, saturating reciprocals
    // and a few points well inside and outside the set.
    task automatic test_directed_points();
        send_point(32'd0, 32'd0);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'd0);
        send_point(32'd0, 32'h7FFF_FFFF);
        send_point(32'd1, 32'd0);
        send_point(32'hFFFF_FFFF, 32'd0);
        send_point(32'd0, 32'd1);
        send_point(32'd0, 32'hFFFF_FFFF);
        send_point(32'h0400_0000, 32'd0);
        send_point(32'hFC00_0000, 32'd0);
        send_point(32'hFCCC_CCCD, 32'd0);
        send_point(32'd0, 32'h0400_0000);
        send_point(32'h0200_0000, 32'h0200_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'hAAAA_AAAA, 32'h5555_5555);
        drain_results();
    endtask

    // The edges of the limit register, zero included.
    task automatic test_limit_extremes();
        write_limit(8'd0);
        send_point(32'd0, 32'd0);
        send_point(32'h0400_0000, 32'd0);
        send_random(20);
        write_limit(8'd1);
        send_point(32'd0, 32'd0);
        send_random(300);
        write_limit(8'd255);
        send_point(32'd0, 32'd0);
        send_random(40);
    endtask

    task automatic test_random_limits();
        write_limit(8'd8);
        send_random(400);
        write_limit(8'd32);
        send_random(400);
        write_limit(8'd100);
        send_random(150);
        write_limit(LIMIT_RESET);
        send_random(40);
    endtask

    // The receiver holds off for a long stretch while points keep coming,
    // so the internal queue fills and the input stalls.
    task automatic test_backpressure();
        write_limit(8'd16);
        hold_request <= 1'b1;
        send_random(50);
        drain_results();
    endtask

    // Result checker and receiver stall pattern. Ready cycles through phases
    // of always ready, random stalls and a periodic pattern, and honors a
    // long hold-off when one is requested.
    int rx_cycle = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        escape_t exp_res;
        rx_cycle <= rx_cycle + 1;
        if (res_if.valid && res_if.ready) begin
            if (pending_escapes.size() == 0) begin
                $error("result transaction with no point pending");
                error_count++;
            end else begin
                exp_res = pending_escapes.pop_front();
                if (res_if.escaped !== exp_res.escaped) begin
                    $error("escaped: expected %0d actual %0d",
                           exp_res.escaped, res_if.escaped);
                    error_count++;
                end
                if (res_if.iterations !== exp_res.iterations) begin
                    $error("iterations: expected %0d actual %0d",
                           exp_res.iterations, res_if.iterations);
                    error_count++;
                end
            end
        end
        if (hold_request) begin
            hold_request <= 1'b0;
            hold_left    <= 3000;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            case ((rx_cycle / 3000) % 3)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 9) < 6);
                default: res_if.ready <= (rx_cycle % 7 != 0);
            endcase
        end
    end

    initial begin
        pt_if.valid      = 1'b0;
        pt_if.real_coord = '0;
        pt_if.imag_coord = '0;
        res_if.ready     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_limit_extremes();
        test_random_limits();
        test_backpressure();
        drain_results();
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #30_000_000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule

### sim.f
rtl/core/ime_pkg.sv
rtl/core/ime_if.sv
rtl/core/ime_front.sv
rtl/core/ime_queue.sv
rtl/core/ime_back.sv
rtl/core/inverted_mandelbrot_escape_top.sv
bench/tb_top.sv
